@@ rtl/lss_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_pkg
// Shared widths, codes and types of the LED strip frame serializer.
// ============================================================================
package lss_pkg;

   // Payload widths.
   localparam int COLOUR_W   = 8;
   localparam int BYTE_W     = 8;
   localparam int BRIGHT_W   = 5;
   localparam int COUNT_W    = 10;
   localparam int CSR_W      = 10;
   localparam int CSR_IDX_W  = 1;

   // Widest clamped frame length, with room for the rounding term.
   localparam int LEN_W      = 11;
   // End byte count: (length + 14) / 16 over the whole parameter range.
   localparam int END_CNT_W  = LEN_W - 4;

   localparam int MAX_LEDS_DEFAULT = 512;

   // Stream constants.
   localparam logic [BYTE_W-1:0] LED_HEADER = 8'hE0;
   localparam logic [LEN_W-1:0]  END_ROUND  = 11'd14;
   localparam int                START_BYTES = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_LED_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

   // Work descriptor passed from the front to the back.
   typedef struct packed {
      logic [COLOUR_W-1:0]  red;
      logic [COLOUR_W-1:0]  green;
      logic [COLOUR_W-1:0]  blue;
      logic [BRIGHT_W-1:0]  bright;
      logic                 start;
      logic                 last_led;
      logic [END_CNT_W-1:0] end_cnt;
   } task_type;

   // Handshake between the queue and the back sequencer.
   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

   // Phases of the byte sequencer.
   typedef enum logic [1:0] {
      SEQ_START,
      SEQ_LED,
      SEQ_END
   } seq_state_type;

endpackage

@@ rtl/lss_req_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_req_if
// Colour channel: one beat carries the colour of one LED.
// ============================================================================
interface lss_req_if;
   logic                         valid;
   logic                         ready;
   logic [lss_pkg::COLOUR_W-1:0] red;
   logic [lss_pkg::COLOUR_W-1:0] green;
   logic [lss_pkg::COLOUR_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/lss_rsp_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_rsp_if
// Byte channel: one beat carries one byte of the strip bit stream.
// ============================================================================
interface lss_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lss_pkg::BYTE_W-1:0] out_byte;
   logic                       run_last;
   logic                       frame_done;

   modport source (output valid, output out_byte, output run_last, output frame_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_done,
                   output ready);
endinterface

@@ rtl/led_strip_frame_serializer.sv @@
`timescale 1ns / 1ps
// A colour beat is written into a two-entry descriptor queue, which absorbs the
// front. Throughput: one byte per cycle while the receiver is ready and work is
// queued, from the single output register of the byte sequencer, so an LED takes
// 4 bytes, plus 4 at the start of a frame and (length + 14) / 16 after its last LED.
// Reset: synchronous; LED position to start of frame, LED count 1,
// brightness 31, queue and output stage empty.
// ============================================================================
// led_strip_frame_serializer
// Encodes per-LED colours into the byte stream of a two-wire LED strip.
// ============================================================================
module led_strip_frame_serializer #(
   parameter int MAX_LEDS = lss_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   lss_req_if.sink                       req,
   lss_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [lss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lss_pkg::CSR_W-1:0]     csr_wdata
);

   logic                   queue_full;
   logic                   push;
   lss_pkg::task_type      push_task;
   logic                   head_valid;
   lss_pkg::task_type      head_task;
   lss_pkg::queue_ctl_type qctl;

   // Front: configuration, position and classification.
   lss_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_task  (push_task)
   );

   // Descriptor queue.
   lss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_task  (push_task),
      .full       (queue_full),
      .pop        (qctl.pop),
      .head_valid (head_valid),
      .head_task  (head_task)
   );

   // Back: byte sequencer and output stage.
   lss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_task  (head_task),
      .qctl       (qctl),
      .rsp        (rsp)
   );

endmodule

@@ rtl/lss_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_front
// Holds the configuration and the LED position, and turns each colour beat
// into a work descriptor for the byte sequencer.
// ============================================================================
module lss_front #(
   parameter int MAX_LEDS = lss_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   lss_req_if.sink                       req,
   input  logic                          csr_wr_en,
   input  logic [lss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lss_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          queue_full,
   output logic                          push,
   output lss_pkg::task_type             push_task
);

   localparam int POS_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam logic [lss_pkg::LEN_W-1:0] LIMIT = lss_pkg::LEN_W'(MAX_LEDS);

   logic [lss_pkg::COUNT_W-1:0]  led_count_ff;
   logic [lss_pkg::BRIGHT_W-1:0] bright_ff;
   logic [POS_W-1:0]             pos_ff;
   logic [POS_W-1:0]             pos_in;

   logic [lss_pkg::LEN_W-1:0] raw_len;
   logic [lss_pkg::LEN_W-1:0] frame_len;
   logic [lss_pkg::LEN_W-1:0] end_sum;
   logic [POS_W:0]            next_pos;
   logic                      last_led;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= lss_pkg::COUNT_W'(1);
         bright_ff    <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            lss_pkg::REG_LED_COUNT:  led_count_ff <= csr_wdata[lss_pkg::COUNT_W-1:0];
            lss_pkg::REG_BRIGHTNESS: bright_ff    <= csr_wdata[lss_pkg::BRIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame length clamped to one up to the strip size.
   always_comb begin
      raw_len = {1'b0, led_count_ff};
      if (raw_len == '0) begin
         frame_len = lss_pkg::LEN_W'(1);
      end else if (raw_len > LIMIT) begin
         frame_len = LIMIT;
      end else begin
         frame_len = raw_len;
      end
   end

   // Classification of the beat: start of frame, last LED and end bytes.
   always_comb begin
      next_pos = {1'b0, pos_ff} + 1'b1;
      last_led = lss_pkg::LEN_W'(next_pos) >= frame_len;
      end_sum  = frame_len + lss_pkg::END_ROUND;

      push_task.red      = req.red;
      push_task.green    = req.green;
      push_task.blue     = req.blue;
      push_task.bright   = bright_ff;
      push_task.start    = (pos_ff == '0);
      push_task.last_led = last_led;
      push_task.end_cnt  = last_led ? end_sum[lss_pkg::LEN_W-1:4] : '0;

      pos_in = last_led ? '0 : next_pos[POS_W-1:0];
   end

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // LED position within the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (push) begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ rtl/lss_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_queue
// Two-entry queue of work descriptors between the front and the back.
// ============================================================================
module lss_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lss_pkg::task_type     push_task,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output lss_pkg::task_type     head_task
);

   lss_pkg::task_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic [1:0]        fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head_task  = entry_ff[rd_ptr_ff];

   // Storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

@@ rtl/lss_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_back
// Byte sequencer: walks start, LED and end bytes of each descriptor and
// drives them through a registered output stage.
// ============================================================================
module lss_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  lss_pkg::task_type     head_task,
   output lss_pkg::queue_ctl_type qctl,
   lss_rsp_if.source             rsp
);

   lss_pkg::seq_state_type         state_ff, state_in;
   lss_pkg::task_type              task_ff, task_in;
   logic [lss_pkg::END_CNT_W-1:0]  idx_ff, idx_in;
   logic                           active_ff, active_in;

   logic                           rsp_valid_ff;
   logic [lss_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           done_ff, done_in;

   lss_pkg::seq_state_type         cur_state;
   lss_pkg::task_type              cur_task;
   logic [lss_pkg::END_CNT_W-1:0]  cur_idx;
   logic                           have;
   logic                           advance;
   logic                           emit;
   logic [lss_pkg::END_CNT_W-1:0]  idx_next;

   // The output register moves when it is empty or its beat is taken.
   assign advance = !rsp_valid_ff || rsp.ready;

   // Work source: the descriptor in progress, else the queue head.
   always_comb begin
      if (active_ff) begin
         cur_task  = task_ff;
         cur_state = state_ff;
         cur_idx   = idx_ff;
      end else begin
         cur_task  = head_task;
         cur_state = head_task.start ? lss_pkg::SEQ_START : lss_pkg::SEQ_LED;
         cur_idx   = '0;
      end
      have       = active_ff || head_valid;
      emit       = advance && have;
      qctl.valid = head_valid;
      qctl.pop   = emit && !active_ff;
   end

   // Next phase and the byte of this step.
   always_comb begin
      idx_next  = cur_idx + 1'b1;
      state_in  = cur_state;
      idx_in    = idx_next;
      active_in = 1'b1;
      task_in   = cur_task;
      byte_in   = '0;
      last_in   = 1'b0;
      done_in   = 1'b0;
      case (cur_state)
         lss_pkg::SEQ_START: begin
            if (cur_idx == lss_pkg::END_CNT_W'(lss_pkg::START_BYTES - 1)) begin
               state_in = lss_pkg::SEQ_LED;
               idx_in   = '0;
            end
         end
         lss_pkg::SEQ_LED: begin
            case (cur_idx[1:0])
               2'd0:    byte_in = lss_pkg::LED_HEADER
                                  | lss_pkg::BYTE_W'(cur_task.bright);
               2'd1:    byte_in = cur_task.blue;
               2'd2:    byte_in = cur_task.green;
               default: byte_in = cur_task.red;
            endcase
            if (cur_idx[1:0] == 2'd3) begin
               idx_in = '0;
               if (cur_task.end_cnt != '0) begin
                  state_in = lss_pkg::SEQ_END;
               end else begin
                  active_in = 1'b0;
                  last_in   = 1'b1;
                  done_in   = cur_task.last_led;
               end
            end
         end
         lss_pkg::SEQ_END: begin
            if (idx_next == cur_task.end_cnt) begin
               active_in = 1'b0;
               last_in   = 1'b1;
               done_in   = 1'b1;
            end
         end
         default: begin
            active_in = 1'b0;
         end
      endcase
   end

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         state_ff     <= lss_pkg::SEQ_START;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= have;
         if (have) begin
            active_ff <= active_in;
            state_ff  <= state_in;
            idx_ff    <= idx_in;
         end
      end
   end

   // Descriptor in progress and output payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         task_ff <= task_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = byte_ff;
   assign rsp.run_last   = last_ff;
   assign rsp.frame_done = done_ff;

endmodule

@@ sim/lss_byte_stream_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lss_byte_stream_checker
// Watches the colour, byte and register ports of the LED strip serializer,
// predicts the byte stream that every colour beat causes and compares each
// byte beat, field by field, with the oldest byte still expected.
// ============================================================================
module lss_byte_stream_checker #(
   parameter int MAX_LEDS = lss_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   lss_req_if                            req,
   lss_rsp_if                            rsp,
   input  logic                          csr_wr_en,
   input  logic [lss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lss_pkg::CSR_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   typedef struct packed {
      logic [lss_pkg::BYTE_W-1:0] out_byte;
      logic                       run_last;
      logic                       frame_done;
   } strip_byte_type;

   // Bytes still owed by the block, oldest first.
   strip_byte_type                expected_bytes[$];
   strip_byte_type                want;
   logic [lss_pkg::COUNT_W-1:0]   led_count_q;
   logic [lss_pkg::BRIGHT_W-1:0]  brightness_q;
   logic [8:0]                    led_pos_q;
   int                            errors = 0;

   function automatic strip_byte_type strip_byte(input logic [lss_pkg::BYTE_W-1:0] value,
                                                 input logic done);
      strip_byte_type b;
      b.out_byte   = value;
      b.run_last   = 1'b0;
      b.frame_done = done;
      return b;
   endfunction

   // Appends the bytes of one LED, with the frame's start and end bytes
   // where they fall, to the expected stream and moves the frame position on.
   task automatic encode_led(input logic [lss_pkg::COLOUR_W-1:0] red,
                             input logic [lss_pkg::COLOUR_W-1:0] green,
                             input logic [lss_pkg::COLOUR_W-1:0] blue);
      strip_byte_type seq[$];
      strip_byte_type item;
      int             frame_len;
      int             next_pos;
      int             end_n;
      int             i;
      bit             last_led;

      // A zero count acts as one LED, and counts beyond the maximum clamp.
      frame_len = int'(led_count_q);
      if (frame_len < 1) frame_len = 1;
      if (frame_len > MAX_LEDS) frame_len = MAX_LEDS;
      next_pos = int'(led_pos_q) + 1;
      last_led = (next_pos >= frame_len);
      end_n    = last_led ? (frame_len + 14) / 16 : 0;

      if (led_pos_q == '0) begin
         for (i = 0; i < lss_pkg::START_BYTES; i++) begin
            seq.push_back(strip_byte(8'h00, 1'b0));
         end
      end
      seq.push_back(strip_byte(lss_pkg::LED_HEADER | {3'b000, brightness_q}, 1'b0));
      seq.push_back(strip_byte(blue, 1'b0));
      seq.push_back(strip_byte(green, 1'b0));
      // With no end bytes the red byte closes the frame.
      seq.push_back(strip_byte(red, last_led && end_n == 0));
      for (i = 0; i < end_n; i++) seq.push_back(strip_byte(8'h00, i + 1 == end_n));

      for (i = 0; i < seq.size(); i++) begin
         item = seq[i];
         item.run_last = (i == seq.size() - 1);
         expected_bytes.push_back(item);
      end

      led_pos_q = last_led ? 9'd0 : next_pos[8:0];
   endtask

   // Byte beats are checked before the colour beat of the same edge is
   // predicted, so that the front of the queue is always the oldest byte.
   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         led_count_q  = lss_pkg::COUNT_W'(1);
         brightness_q = lss_pkg::BRIGHT_W'(31);
         led_pos_q    = '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected nothing, got %02h", rsp.out_byte);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp.out_byte);
                  errors++;
               end
               if (rsp.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp.run_last);
                  errors++;
               end
               if (rsp.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, got %0b", want.frame_done,
                         rsp.frame_done);
                  errors++;
               end
            end
         end

         if (req.valid && req.ready) encode_led(req.red, req.green, req.blue);

         if (csr_wr_en) begin
            case (csr_index)
               lss_pkg::REG_LED_COUNT:  led_count_q  = csr_wdata[lss_pkg::COUNT_W-1:0];
               lss_pkg::REG_BRIGHTNESS: brightness_q = csr_wdata[lss_pkg::BRIGHT_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending    <= expected_bytes.size();
   end

endmodule

@@ sim/led_strip_frame_serializer_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// led_strip_frame_serializer_tb
// Drives colour beats and register writes into the LED strip serializer with
// random gaps and back-pressure, and reports the verdict of the byte checker.
// ============================================================================
module led_strip_frame_serializer_tb;

   localparam int NUM_PHASES = 9;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [lss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lss_pkg::CSR_W-1:0]     csr_wdata = '0;

   int idle_pct  = 0;
   int stall_pct = 0;
   int fail_count;
   int pending;

   // LED count of each random phase; a negative entry picks a small count.
   // The two long phases together run past one full frame at the largest length.
   int phase_count[NUM_PHASES] = '{5, 1023, 512, 17, 0, -1, 2, -1, -1};
   int phase_items[NUM_PHASES] = '{5, 256, 257, 8, 4, 16, 4, 8, 8};

   lss_req_if req_ch ();
   lss_rsp_if rsp_ch ();

   always #2 clock = ~clock;

   led_strip_frame_serializer #(
      .MAX_LEDS (lss_pkg::MAX_LEDS_DEFAULT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lss_byte_stream_checker #(
      .MAX_LEDS (lss_pkg::MAX_LEDS_DEFAULT)
   ) stream_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Receiver back-pressure, redrawn on every edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one colour beat after a random gap and returns at the edge that
   // takes it.
   task automatic send_led(input logic [lss_pkg::COLOUR_W-1:0] r,
                           input logic [lss_pkg::COLOUR_W-1:0] g,
                           input logic [lss_pkg::COLOUR_W-1:0] b);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.red   <= r;
      req_ch.green <= g;
      req_ch.blue  <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops sending and waits until every expected byte has left the block.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lss_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= lss_pkg::CSR_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int p;
      int i;
      int count;
      int bright;

      req_ch.valid = 1'b0;
      req_ch.red   = '0;
      req_ch.green = '0;
      req_ch.blue  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: one-LED frames with no end bytes.
      send_led(8'h00, 8'h00, 8'h00);
      send_led(8'hFF, 8'hFF, 8'hFF);
      send_led(8'hAA, 8'h55, 8'h0F);

      // A zero count behaves as a single LED; brightness at its minimum.
      drain();
      write_reg(lss_pkg::REG_LED_COUNT, 0);
      write_reg(lss_pkg::REG_BRIGHTNESS, 0);
      send_led(8'h01, 8'h80, 8'h7F);
      send_led(8'hFE, 8'h01, 8'h80);

      // Two-LED frames; the third beat opens a new frame.
      drain();
      write_reg(lss_pkg::REG_LED_COUNT, 2);
      write_reg(lss_pkg::REG_BRIGHTNESS, 21);
      send_led(8'h12, 8'h34, 8'h56);
      send_led(8'h78, 8'h9A, 8'hBC);
      send_led(8'hDE, 8'hF0, 8'h0F);

      // Lengthen the frame, then shorten it below the position reached.
      drain();
      write_reg(lss_pkg::REG_LED_COUNT, 18);
      write_reg(lss_pkg::REG_BRIGHTNESS, 31);
      send_led(8'h80, 8'h00, 8'hFF);
      send_led(8'h7F, 8'hFF, 8'h00);
      send_led(8'hC3, 8'h3C, 8'h99);
      drain();
      write_reg(lss_pkg::REG_LED_COUNT, 2);
      send_led(8'h66, 8'h11, 8'hEE);

      // A three-LED frame with one end byte.
      drain();
      write_reg(lss_pkg::REG_LED_COUNT, 3);
      send_led(8'h01, 8'h02, 8'h04);
      send_led(8'h08, 8'h10, 8'h20);
      send_led(8'h40, 8'h80, 8'hFF);

      // Random phases, each with its own settings and idling pattern.
      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         count  = (phase_count[p] < 0) ? int'($urandom_range(1, 40)) : phase_count[p];
         bright = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 31 : int'($urandom_range(0, 31));
         write_reg(lss_pkg::REG_LED_COUNT, count);
         write_reg(lss_pkg::REG_BRIGHTNESS, bright);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         for (i = 0; i < phase_items[p]; i++) begin
            // Once, hold the sender back until the stream has run dry.
            if (p == 5 && i == phase_items[p] / 2) drain();
            send_led(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
